// File: sv/ppta_pkg.sv
package ppta_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int PROBE_LIMIT_DEF   = 8;

  localparam logic [63:0] HASH_MUL_A = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_MUL_B = 64'hbf58476d1ce4e5b9;

  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_LOSS   = 2'd1;
  localparam logic [1:0] OP_EXPORT = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] REC_LOSS  = 2'd0;
  localparam logic [1:0] REC_COUNT = 2'd1;
  localparam logic [1:0] REC_END   = 2'd2;

  localparam logic [1:0] CFG_IP_VERSION = 2'd0;
  localparam logic [1:0] CFG_USE_DEST   = 2'd1;
  localparam logic [1:0] CFG_PREFIX_LEN = 2'd2;

  localparam logic [7:0] PREFIX_LEN_RST = 8'd32;

  // multiply steps of the hash
  localparam logic [2:0] STEP_MIX  = 3'd2;
  localparam logic [2:0] STEP_LAST = 3'd5;

  localparam int WORD_W = 1 + 64 + 64 + 64;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_MIX,
    ST_BASE,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_PLACE,
    ST_UPD,
    ST_EXP_START,
    ST_EXP_RD,
    ST_EXP_CHK
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic mul;
    logic acc;
    logic mix;
    logic base;
    logic probe_chk;
    logic upd_wr;
    logic new_wr;
    logic note_loss;
    logic exp_begin;
    logic emit_loss;
    logic rd_cursor;
    logic emit_end;
    logic exp_adv;
    logic exp_take;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       in_short;
    logic [2:0] step;
    logic       clr_done;
    logic       hit;
    logic       probe_last;
    logic       have_free;
    logic       phase_on;
    logic       lost_nz;
    logic       cur_end;
    logic       slot_used;
    logic       out_busy;
  } status_t;

endpackage

// File: sv/ppta_ram.sv
module ppta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ppta_ctrl.sv
module ppta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppta_pkg::status_t st,
  output ppta_pkg::cmd_t    cmd
);
  import ppta_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE) && !st.out_busy;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (st.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (st.in_op == OP_PACKET && !st.in_short) state_nxt = ST_MUL;
          else if (st.in_op == OP_EXPORT) state_nxt = ST_EXP_START;
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        if (st.step == STEP_MIX) state_nxt = ST_MIX;
        else if (st.step == STEP_LAST) state_nxt = ST_BASE;
        else state_nxt = ST_MUL;
      end
      ST_MIX:    state_nxt = ST_MUL;
      ST_BASE:   state_nxt = ST_PRB_RD;
      ST_PRB_RD: state_nxt = ST_PRB_CHK;
      ST_PRB_CHK: begin
        if (st.hit) state_nxt = ST_UPD;
        else if (st.probe_last) state_nxt = ST_PLACE;
        else state_nxt = ST_PRB_RD;
      end
      ST_PLACE: state_nxt = ST_IDLE;
      ST_UPD:   state_nxt = ST_IDLE;
      ST_EXP_START: begin
        if (!st.phase_on && st.lost_nz) state_nxt = ST_IDLE;
        else state_nxt = ST_EXP_RD;
      end
      ST_EXP_RD: begin
        if (st.cur_end) state_nxt = ST_IDLE;
        else state_nxt = ST_EXP_CHK;
      end
      ST_EXP_CHK: begin
        if (st.slot_used) state_nxt = ST_IDLE;
        else state_nxt = ST_EXP_RD;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        cmd.load      = accept;
        cmd.note_loss = accept && (st.in_op == OP_LOSS);
      end
      ST_MUL:     cmd.mul = 1'b1;
      ST_ACC:     cmd.acc = 1'b1;
      ST_MIX:     cmd.mix = 1'b1;
      ST_BASE:    cmd.base = 1'b1;
      ST_PRB_RD:  cmd = '0;
      ST_PRB_CHK: cmd.probe_chk = 1'b1;
      ST_PLACE: begin
        cmd.new_wr    = st.have_free;
        cmd.note_loss = !st.have_free;
      end
      ST_UPD: cmd.upd_wr = 1'b1;
      ST_EXP_START: begin
        cmd.exp_begin = !st.phase_on;
        cmd.emit_loss = !st.phase_on && st.lost_nz;
      end
      ST_EXP_RD: begin
        cmd.rd_cursor = 1'b1;
        cmd.emit_end  = st.cur_end;
      end
      ST_EXP_CHK: begin
        cmd.rd_cursor = 1'b1;
        cmd.exp_take  = st.slot_used;
        cmd.exp_adv   = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/ppta_dp.sv
module ppta_dp #(
  parameter int TABLE_ENTRIES = ppta_pkg::TABLE_ENTRIES_DEF,
  parameter int PROBE_LIMIT   = ppta_pkg::PROBE_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic [1:0]        in_op,
  input  logic [63:0]       in_header_bytes_0_7,
  input  logic [63:0]       in_header_bytes_8_15,
  input  logic [63:0]       in_header_bytes_16_23,
  input  logic [63:0]       in_header_bytes_24_31,
  input  logic [63:0]       in_header_bytes_32_39,
  input  logic [15:0]       in_captured_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_record_kind,
  output logic [63:0]       out_address_high,
  output logic [63:0]       out_address_low,
  output logic [63:0]       out_byte_total,
  output logic [15:0]       out_loss_total,
  input  ppta_pkg::cmd_t    cmd,
  output ppta_pkg::status_t st
);
  import ppta_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

  logic              ipv6_r, use_dst_r;
  logic [7:0]        prefix_r;

  logic [63:0]       key_hi_r, key_lo_r;
  logic [16:0]       len_r;
  logic [2:0]        step_r;
  logic [63:0]       prod_r, acc_r, z_r;
  logic [IW-1:0]     idx_r, free_idx_r, clr_addr_r;
  logic [PW-1:0]     cnt_r;
  logic              have_free_r;
  logic [15:0]       lost_r;
  logic              phase_r;
  logic [CW-1:0]     cursor_r;
  logic              out_valid_r;
  logic [1:0]        kind_r;
  logic [63:0]       ahi_r, alo_r, bytes_r;
  logic [15:0]       loss_r;

  logic [63:0]       key_hi_nxt, key_lo_nxt, mask_hi, mask_lo;
  logic [16:0]       len_nxt;
  logic [15:0]       v4_len, thr;
  logic [7:0]        p_sat, p_lo;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       x0, z_nxt;
  logic [IW-1:0]     hash, idx_inc;
  logic              we;
  logic [IW-1:0]     waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;
  logic              r_used, hit;
  logic [63:0]       r_khi, r_klo, r_sum;

  ppta_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign {r_used, r_khi, r_klo, r_sum} = rdata;
  assign hit = r_used && (r_khi == key_hi_r) && (r_klo == key_lo_r);

  // key, length and capture check
  always_comb begin
    if (!ipv6_r) thr = use_dst_r ? 16'd20 : 16'd16;
    else         thr = use_dst_r ? 16'd40 : 16'd24;
    v4_len = in_header_bytes_0_7[47:32];
    if (!ipv6_r) begin
      p_sat      = (prefix_r > 8'd32) ? 8'd32 : prefix_r;
      mask_lo    = {32'h0, ~(32'hffffffff >> p_sat)};
      mask_hi    = '0;
      p_lo       = '0;
      key_hi_nxt = '0;
      key_lo_nxt = (use_dst_r ? {32'h0, in_header_bytes_16_23[63:32]}
                              : {32'h0, in_header_bytes_8_15[31:0]}) & mask_lo;
      len_nxt    = (v4_len < 16'd20) ? 17'd20 : {1'b0, v4_len};
    end else begin
      p_sat      = (prefix_r > 8'd128) ? 8'd128 : prefix_r;
      p_lo       = (p_sat > 8'd64) ? (p_sat - 8'd64) : 8'd0;
      mask_hi    = (p_sat >= 8'd64) ? '1 : ~({64{1'b1}} >> p_sat);
      mask_lo    = ~({64{1'b1}} >> p_lo);
      key_hi_nxt = (use_dst_r ? in_header_bytes_24_31 : in_header_bytes_8_15) & mask_hi;
      key_lo_nxt = (use_dst_r ? in_header_bytes_32_39 : in_header_bytes_16_23) & mask_lo;
      len_nxt    = 17'd40 + {1'b0, in_header_bytes_0_7[31:16]};
    end
  end

  // shared 32x32 multiplier operands
  always_comb begin
    case (step_r)
      3'd0:    begin mul_a = key_lo_r[31:0];  mul_b = HASH_MUL_A[31:0];  end
      3'd1:    begin mul_a = key_lo_r[63:32]; mul_b = HASH_MUL_A[31:0];  end
      3'd2:    begin mul_a = key_lo_r[31:0];  mul_b = HASH_MUL_A[63:32]; end
      3'd3:    begin mul_a = z_r[31:0];       mul_b = HASH_MUL_B[31:0];  end
      3'd4:    begin mul_a = z_r[63:32];      mul_b = HASH_MUL_B[31:0];  end
      default: begin mul_a = z_r[31:0];       mul_b = HASH_MUL_B[63:32]; end
    endcase
  end

  assign x0      = key_hi_r ^ acc_r;
  assign z_nxt   = x0 ^ (x0 >> 29);
  assign hash    = acc_r[IW-1:0] ^ acc_r[32+IW-1:32];
  assign idx_inc = (idx_r == IW'(TABLE_ENTRIES - 1)) ? '0 : idx_r + 1'b1;

  // store port selection
  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = '0;
    if (cmd.clear_wr) begin
      we    = 1'b1;
      waddr = clr_addr_r;
    end else if (cmd.exp_take) begin
      we    = 1'b1;
      waddr = cursor_r[IW-1:0];
    end else if (cmd.upd_wr) begin
      we    = 1'b1;
      wdata = {1'b1, key_hi_r, key_lo_r, r_sum + 64'(len_r)};
    end else if (cmd.new_wr) begin
      we    = 1'b1;
      waddr = free_idx_r;
      wdata = {1'b1, key_hi_r, key_lo_r, 64'(len_r)};
    end
  end

  assign raddr = cmd.rd_cursor ? cursor_r[IW-1:0] : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipv6_r      <= 1'b0;
      use_dst_r   <= 1'b0;
      prefix_r    <= PREFIX_LEN_RST;
      clr_addr_r  <= '0;
      lost_r      <= '0;
      phase_r     <= 1'b0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IP_VERSION: ipv6_r    <= cfg_wdata[0];
          CFG_USE_DEST:   use_dst_r <= cfg_wdata[0];
          CFG_PREFIX_LEN: prefix_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clear_wr) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.note_loss && lost_r != 16'hffff) lost_r <= lost_r + 1'b1;
      if (cmd.emit_loss) lost_r <= '0;
      if (cmd.exp_begin) begin
        phase_r  <= 1'b1;
        cursor_r <= '0;
      end
      if (cmd.exp_adv) cursor_r <= cursor_r + 1'b1;
      if (cmd.emit_end) begin
        phase_r  <= 1'b0;
        cursor_r <= '0;
      end
      if (cmd.emit_loss || cmd.emit_end || cmd.exp_take) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_hi_r <= key_hi_nxt;
      key_lo_r <= key_lo_nxt;
      len_r    <= len_nxt;
      step_r   <= '0;
    end
    if (cmd.mul) prod_r <= mul_a * mul_b;
    if (cmd.acc) begin
      if (step_r == 3'd0 || step_r == 3'd3) acc_r <= prod_r;
      else acc_r <= acc_r + {prod_r[31:0], 32'h0};
      step_r <= step_r + 1'b1;
    end
    if (cmd.mix) z_r <= z_nxt;
    if (cmd.base) begin
      idx_r       <= hash;
      cnt_r       <= '0;
      have_free_r <= 1'b0;
    end
    if (cmd.probe_chk && !hit) begin
      idx_r <= idx_inc;
      cnt_r <= cnt_r + 1'b1;
      if (!r_used && !have_free_r) begin
        have_free_r <= 1'b1;
        free_idx_r  <= idx_r;
      end
    end
    if (cmd.emit_loss) begin
      kind_r  <= REC_LOSS;
      ahi_r   <= '0;
      alo_r   <= '0;
      bytes_r <= '0;
      loss_r  <= lost_r;
    end else if (cmd.emit_end) begin
      kind_r  <= REC_END;
      ahi_r   <= '0;
      alo_r   <= '0;
      bytes_r <= '0;
      loss_r  <= '0;
    end else if (cmd.exp_take) begin
      kind_r  <= REC_COUNT;
      ahi_r   <= r_khi;
      alo_r   <= r_klo;
      bytes_r <= r_sum;
      loss_r  <= '0;
    end
  end

  always_comb begin
    st            = '0;
    st.in_op      = in_op;
    st.in_short   = in_captured_length < thr;
    st.step       = step_r;
    st.clr_done   = clr_addr_r == IW'(TABLE_ENTRIES - 1);
    st.hit        = hit;
    st.probe_last = cnt_r == PW'(PROBE_LIMIT - 1);
    st.have_free  = have_free_r;
    st.phase_on   = phase_r;
    st.lost_nz    = lost_r != '0;
    st.cur_end    = cursor_r == CW'(TABLE_ENTRIES);
    st.slot_used  = r_used;
    st.out_busy   = out_valid_r;
  end

  assign out_valid        = out_valid_r;
  assign out_record_kind  = kind_r;
  assign out_address_high = ahi_r;
  assign out_address_low  = alo_r;
  assign out_byte_total   = bytes_r;
  assign out_loss_total   = loss_r;

endmodule

// File: sv/per_prefix_traffic_accounting.sv
// channel   direction  handshake           payload
// in_       input      in_valid/in_ready   op, five header words, captured length
// out_      output     out_valid/out_ready record kind, address, bytes, loss
// cfg_      input      cfg_we              cfg_index, cfg_wdata (8 bits)
//
// one beat at a time; a packet is hashed on the shared 32x32 multiplier,
// then up to PROBE_LIMIT slots are read and checked, then it is written or lost
// loss events are counted on acceptance; an export step reads, then checks, each slot scanned
// after reset a clearing pass over all TABLE_ENTRIES slots holds in_ready low
// in_ready is low while a record waits in the output register
module per_prefix_traffic_accounting #(
  parameter int TABLE_ENTRIES = ppta_pkg::TABLE_ENTRIES_DEF,
  parameter int PROBE_LIMIT   = ppta_pkg::PROBE_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_header_bytes_0_7,
  input  logic [63:0] in_header_bytes_8_15,
  input  logic [63:0] in_header_bytes_16_23,
  input  logic [63:0] in_header_bytes_24_31,
  input  logic [63:0] in_header_bytes_32_39,
  input  logic [15:0] in_captured_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_record_kind,
  output logic [63:0] out_address_high,
  output logic [63:0] out_address_low,
  output logic [63:0] out_byte_total,
  output logic [15:0] out_loss_total
);
  import ppta_pkg::*;

  cmd_t    cmd;
  status_t st;

  ppta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ppta_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .PROBE_LIMIT(PROBE_LIMIT)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_op                 (in_op),
    .in_header_bytes_0_7   (in_header_bytes_0_7),
    .in_header_bytes_8_15  (in_header_bytes_8_15),
    .in_header_bytes_16_23 (in_header_bytes_16_23),
    .in_header_bytes_24_31 (in_header_bytes_24_31),
    .in_header_bytes_32_39 (in_header_bytes_32_39),
    .in_captured_length    (in_captured_length),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_record_kind       (out_record_kind),
    .out_address_high      (out_address_high),
    .out_address_low       (out_address_low),
    .out_byte_total        (out_byte_total),
    .out_loss_total        (out_loss_total),
    .cmd                   (cmd),
    .st                    (st)
  );

endmodule
